// File: sv/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg: shared definitions for the life generation engine
// Payload layouts, command codes, sequencer states and the neighbourhood
// bundle passed to the cell rule unit.
// ----------------------------------------------------------------------------
package lge_pkg;

	// Default grid dimensions.
	localparam int LGE_GRID_WIDTH  = 64;
	localparam int LGE_GRID_HEIGHT = 64;

	// Fixed field widths of the command and result payloads.
	localparam int ADDR_W  = 6;
	localparam int COUNT_W = 13;

	// Command codes; the fourth code does nothing and returns zeros.
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] row;
		logic [ADDR_W-1:0] column;
		logic              write_value;
	} lge_cmd_t;

	typedef struct packed {
		logic               read_value;
		logic [COUNT_W-1:0] live_count;
	} lge_res_t;

	// The eight neighbours and the centre of one cell; each row is {left, centre, right}.
	typedef struct packed {
		logic [2:0] above;
		logic       left;
		logic       centre;
		logic       right;
		logic [2:0] below;
	} lge_nbhd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_MODIFY,
		ST_PICK,
		ST_LOAD_TOP,
		ST_LOAD_MID,
		ST_ROW_START,
		ST_CELL,
		ST_ROW_END,
		ST_EMIT
	} lge_state_t;

endpackage

// File: sv/lge_chan_if.sv
// ----------------------------------------------------------------------------
// lge_chan_if: valid/ready channel
// Carries one payload per transfer; a transfer happens on a rising clock
// edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface lge_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport monitor (input valid, input ready, input data);

endinterface

// File: sv/lge_cell_unit.sv
// ----------------------------------------------------------------------------
// lge_cell_unit: B3/S23 rule for one cell
// Counts the live neighbours of one cell and decides whether it lives in
// the next generation. Shared by every cell of a step.
// ----------------------------------------------------------------------------
module lge_cell_unit
	import lge_pkg::*;
(
	input  lge_nbhd_t nbhd,
	output logic      alive
);

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	logic [3:0] count;

	// Population of the eight surrounding cells.
	always_comb begin
		count = 4'(nbhd.above[0]) + 4'(nbhd.above[1]) + 4'(nbhd.above[2])
		      + 4'(nbhd.left) + 4'(nbhd.right)
		      + 4'(nbhd.below[0]) + 4'(nbhd.below[1]) + 4'(nbhd.below[2]);
	end

	// Born with exactly three, survives with two or three.
	assign alive = (count == BIRTH_COUNT) || (nbhd.centre && (count == SURVIVE_COUNT));

endmodule

// File: sv/life_generation_engine.sv
// ----------------------------------------------------------------------------
// life_generation_engine: cellular automaton grid under rule B3/S23
// Row-organised grid store with two banks, a three-row window and one
// shared cell rule unit driven by a small sequencer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid to dead, one row per cycle, before
// it takes its first command. Each command gives exactly one result. For a
// write or a read the addressed row is fetched into the read register; a
// write then stores the row back with the cell replaced, and a read picks
// out the cell. An unused code or an address outside the grid goes straight
// to the result. A step fetches the top two rows, then the shared rule unit
// judges one cell per cycle along each row, and between rows the finished
// row is written back while the row two below is fetched.
// The new generation goes to the idle bank, which then becomes current. A
// finished result sits in an output register, so the next command is taken
// while it waits. Only rows and columns 0 to 63 can be addressed; writes
// outside the grid are dropped and reads there return zero.
// ----------------------------------------------------------------------------
module life_generation_engine
	import lge_pkg::*;
#(
	parameter int GRID_WIDTH  = LGE_GRID_WIDTH,
	parameter int GRID_HEIGHT = LGE_GRID_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	lge_chan_if.sink   cmd,
	lge_chan_if.source res
);

	localparam int COL_W = $clog2(GRID_WIDTH);
	localparam int ROW_W = $clog2(GRID_HEIGHT);
	localparam int IDX_W = (ROW_W > COL_W) ? ROW_W : COL_W;
	localparam int XW    = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

	lge_state_t             state_q, state_d;
	logic                   bank_q;
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [1:0]             op_q;
	logic                   wval_q;
	logic                   pick_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic                   ov_q;
	lge_res_t               od_q;

	logic [GRID_WIDTH-1:0]  mem_q [0:1][0:GRID_HEIGHT-1];
	logic [GRID_WIDTH-1:0]  rd_q;
	logic [GRID_WIDTH-1:0]  up_q, mid_q, dn_q, nrow_q;

	logic                   rd_en, wr_en, rd_bank, wr_bank;
	logic [ROW_W-1:0]       rd_row, wr_row;
	logic [GRID_WIDTH-1:0]  wr_data, mod_row;

	logic [XW-1:0]          in_row_x, in_col_x, row_plus2_x;
	logic                   in_inside, row_last, col_last, col_first, more_rows;
	logic                   accept, out_free, alive;
	lge_nbhd_t              nbhd;

	// Address checks and loop bounds.
	assign in_row_x    = XW'(cmd.data.row);
	assign in_col_x    = XW'(cmd.data.column);
	assign in_inside   = (in_row_x < XW'(GRID_HEIGHT)) && (in_col_x < XW'(GRID_WIDTH));
	assign row_last    = (row_q == ROW_W'(GRID_HEIGHT - 1));
	assign col_last    = (col_q == COL_W'(GRID_WIDTH - 1));
	assign col_first   = (col_q == '0);
	assign row_plus2_x = XW'(row_q) + XW'(2);
	assign more_rows   = (row_plus2_x < XW'(GRID_HEIGHT));
	assign accept      = cmd.valid && cmd.ready;
	assign out_free    = !ov_q || res.ready;

	// Window around the current cell: bit 0 of each rotated row is the
	// current column, bit 1 the next and the top bit the previous one.
	always_comb begin
		nbhd.above  = {up_q[GRID_WIDTH-1] & ~col_first, up_q[0], up_q[1] & ~col_last};
		nbhd.left   = mid_q[GRID_WIDTH-1] & ~col_first;
		nbhd.centre = mid_q[0];
		nbhd.right  = mid_q[1] & ~col_last;
		nbhd.below  = {dn_q[GRID_WIDTH-1] & ~col_first, dn_q[0], dn_q[1] & ~col_last};
	end

	lge_cell_unit u_cell_unit (
		.nbhd  (nbhd),
		.alive (alive)
	);

	// Fetched row with the addressed cell replaced, for a cell write.
	always_comb begin
		mod_row        = rd_q;
		mod_row[col_q] = wval_q;
	end

	// Sequencer: next state and grid store controls.
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		rd_en     = 1'b0;
		rd_bank   = bank_q;
		rd_row    = row_q;
		wr_en     = 1'b0;
		wr_bank   = bank_q;
		wr_row    = row_q;
		wr_data   = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (row_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if (cmd.data.command == CMD_STEP) begin
						state_d = ST_LOAD_TOP;
					end else if (((cmd.data.command == CMD_WRITE) ||
					              (cmd.data.command == CMD_READ)) && in_inside) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_FETCH: begin
				rd_en   = 1'b1;
				state_d = (op_q == CMD_WRITE) ? ST_MODIFY : ST_PICK;
			end
			ST_MODIFY: begin
				wr_en   = 1'b1;
				wr_data = mod_row;
				state_d = ST_EMIT;
			end
			ST_PICK: begin
				state_d = ST_EMIT;
			end
			ST_LOAD_TOP: begin
				rd_en   = 1'b1;
				rd_row  = '0;
				state_d = ST_LOAD_MID;
			end
			ST_LOAD_MID: begin
				rd_en   = 1'b1;
				rd_row  = ROW_W'(1);
				state_d = ST_ROW_START;
			end
			ST_ROW_START: begin
				state_d = ST_CELL;
			end
			ST_CELL: begin
				if (col_last) begin
					state_d = ST_ROW_END;
				end
			end
			ST_ROW_END: begin
				wr_en   = 1'b1;
				wr_bank = ~bank_q;
				wr_data = nrow_q;
				if (more_rows) begin
					rd_en  = 1'b1;
					rd_row = row_q + ROW_W'(2);
				end
				state_d = row_last ? ST_EMIT : ST_ROW_START;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: state, current bank, counters and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			bank_q  <= 1'b0;
			row_q   <= '0;
			col_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else if (accept) begin
				if (cmd.data.command == CMD_STEP) begin
					row_q <= '0;
					col_q <= '0;
				end else begin
					row_q <= ROW_W'(in_row_x);
					col_q <= COL_W'(in_col_x);
				end
			end else if (state_q == ST_CELL) begin
				col_q <= col_last ? '0 : col_q + COL_W'(1);
			end else if (state_q == ST_ROW_END) begin
				if (row_last) begin
					bank_q <= ~bank_q;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
			if ((state_q == ST_EMIT) && out_free) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Grid store: both generations, one row per entry, registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_bank][wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_bank][rd_row];
		end
	end

	// Datapath: command fields, row window, new row and live count.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.data.command;
			wval_q <= cmd.data.write_value;
			pick_q <= 1'b0;
			cnt_q  <= '0;
		end
		unique case (state_q)
			ST_PICK: begin
				pick_q <= rd_q[col_q];
			end
			ST_LOAD_MID: begin
				up_q  <= '0;
				mid_q <= rd_q;
			end
			ST_ROW_START: begin
				dn_q <= row_last ? '0 : rd_q;
			end
			ST_CELL: begin
				up_q   <= {up_q[0], up_q[GRID_WIDTH-1:1]};
				mid_q  <= {mid_q[0], mid_q[GRID_WIDTH-1:1]};
				dn_q   <= {dn_q[0], dn_q[GRID_WIDTH-1:1]};
				nrow_q <= {alive, nrow_q[GRID_WIDTH-1:1]};
				if (alive && (cnt_q != '1)) begin
					cnt_q <= cnt_q + COUNT_W'(1);
				end
			end
			ST_ROW_END: begin
				up_q  <= mid_q;
				mid_q <= dn_q;
			end
			ST_EMIT: begin
				if (out_free) begin
					od_q.read_value <= pick_q;
					od_q.live_count <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid = ov_q;
	assign res.data  = od_q;

endmodule

// File: sv/lge_checker.sv
// ----------------------------------------------------------------------------
// lge_checker: port-level checks for the life generation engine
// Tracks commands against results and checks result and busy behaviour.
// ----------------------------------------------------------------------------
module lge_checker
	import lge_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     cmd_valid,
	input logic     cmd_ready,
	input logic     res_valid,
	input logic     res_ready,
	input lge_res_t res_data
);

	logic [1:0] pend_q;
	logic       cmd_xfer, res_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign res_xfer = res_valid && res_ready;

	// Commands transferred whose results have not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (cmd_xfer && !res_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (res_xfer && !cmd_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// A result held back keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// Every command leaves the block busy in the cycle after its transfer.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> !cmd_ready)
		else $error("command taken in consecutive cycles");

	// No result appears without a command behind it.
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without a command");

	// At most one finished and one running command.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many commands outstanding");

	// A result carries a cell value or a count, never both.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.read_value && (res_data.live_count != '0)))
		else $error("read value and live count both set");

endmodule

bind life_generation_engine lge_checker u_lge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);

// File: sim/life_generation_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_engine_tb: self-checking bench for the life grid engine
// Writes, reads and generation steps go into the engine with random gaps on
// both channels. A behavioural copy of the grid predicts every response, and
// the responses are checked in order, field by field.
// ----------------------------------------------------------------------------
module life_generation_engine_tb;
	import lge_pkg::*;

	localparam int GRID_H = LGE_GRID_HEIGHT;
	localparam int GRID_W = LGE_GRID_WIDTH;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SURVIVE_MIN = 2;
	localparam int BIRTH_COUNT = 3;
	localparam int unsigned COUNT_MAX = 8191;
	localparam int STEP_CYCLES = GRID_H * (GRID_W + 2) + 3;
	localparam int SETTLE_CYCLES = STEP_CYCLES + 100;
	localparam int ITEM_TARGET = 140;
	localparam int CYCLE_LIMIT = 2_500_000;

	typedef bit grid_t [0:GRID_H-1][0:GRID_W-1];

	typedef struct {
		lge_cmd_t item;
		bit       wait_idle;
	} queued_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	lge_chan_if #(.payload_t(lge_cmd_t)) cmd_if ();
	lge_chan_if #(.payload_t(lge_res_t)) res_if ();

	life_generation_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	grid_t         life_grid;
	queued_cmd_t   command_queue[$];
	lge_res_t      expected_responses[$];
	int unsigned   items_sent = 0;
	int unsigned   results_seen = 0;
	int unsigned   cycle_count = 0;
	int            failures = 0;
	int            useful_count = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	bit            calm_phase = 1'b0;

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// A cell beyond the grid edge is dead; the grid does not wrap.
	function automatic int cell_at(input int r, input int c);
		if (r < 0 || c < 0 || r >= GRID_H || c >= GRID_W)
			return 0;
		return life_grid[r][c];
	endfunction

	// Builds the next generation under B3/S23, commits it and returns the census.
	function automatic logic [COUNT_W-1:0] next_generation_count();
		grid_t       fresh;
		int unsigned alive;
		int          neighbours;
		alive = 0;
		for (int r = 0; r < GRID_H; r++) begin
			for (int c = 0; c < GRID_W; c++) begin
				neighbours = 0;
				for (int dr = -1; dr <= 1; dr++)
					for (int dc = -1; dc <= 1; dc++)
						if (dr != 0 || dc != 0)
							neighbours += cell_at(r + dr, c + dc);
				if (life_grid[r][c])
					fresh[r][c] = (neighbours == SURVIVE_MIN || neighbours == BIRTH_COUNT);
				else
					fresh[r][c] = (neighbours == BIRTH_COUNT);
				alive += fresh[r][c];
			end
		end
		life_grid = fresh;
		return (alive > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0] : alive[COUNT_W-1:0];
	endfunction

	// Applies one command to the grid copy and returns the response it should give.
	function automatic lge_res_t grid_response(input lge_cmd_t c);
		lge_res_t resp;
		bit       on_grid;
		resp = '0;
		on_grid = (int'(c.row) < GRID_H) && (int'(c.column) < GRID_W);
		case (c.command)
			CMD_WRITE: begin
				if (on_grid)
					life_grid[c.row][c.column] = c.write_value;
			end
			CMD_READ: begin
				if (on_grid)
					resp.read_value = life_grid[c.row][c.column];
			end
			CMD_STEP: begin
				resp.live_count = next_generation_count();
			end
			default: begin
			end
		endcase
		return resp;
	endfunction

	// Appends one command to the stimulus; unused codes do not count as work.
	task automatic push_cmd(input logic [1:0] op, input int row, input int column,
			input bit value, input bit hold = 1'b0);
		queued_cmd_t q;
		q.item.command = op;
		q.item.row = row[ADDR_W-1:0];
		q.item.column = column[ADDR_W-1:0];
		q.item.write_value = value;
		q.wait_idle = hold;
		command_queue.push_back(q);
		if (op != CMD_UNUSED)
			useful_count++;
	endtask

	// Command driver: one transfer per item, random gaps between items, and an
	// optional hold until every outstanding response has come back.
	always @(posedge clk) begin : cmd_driver
		bit          fired;
		queued_cmd_t upcoming;
		if (arst_n) begin
			fired = cmd_if.valid && cmd_if.ready;
			if (fired) begin
				items_sent <= items_sent + 1;
				if ($urandom_range(0, 24) == 0)
					calm_phase <= !calm_phase;
			end
			if (!cmd_if.valid || fired) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_if.valid <= 1'b0;
				end else if (command_queue.size() != 0 && (!command_queue[0].wait_idle ||
						items_sent + fired == results_seen)) begin
					upcoming = command_queue.pop_front();
					cmd_if.valid <= 1'b1;
					cmd_if.data <= upcoming.item;
					gap_left = calm_phase ? 0 : idle_length();
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: predicts on each command transfer, then checks each
	// response transfer against the oldest prediction. Also paces res ready.
	always @(posedge clk) begin : res_monitor
		lge_res_t want;
		lge_res_t got;
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready)
				expected_responses.push_back(grid_response(cmd_if.data));
			if (res_if.valid && res_if.ready) begin
				got = res_if.data;
				results_seen <= results_seen + 1;
				if (expected_responses.size() == 0) begin
					$error("unexpected response: read_value %0d live_count %0d",
						got.read_value, got.live_count);
					failures++;
				end else begin
					want = expected_responses.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value mismatch: expected %0d, actual %0d",
							want.read_value, got.read_value);
						failures++;
					end
					if (got.live_count !== want.live_count) begin
						$error("live_count mismatch: expected %0d, actual %0d",
							want.live_count, got.live_count);
						failures++;
					end
				end
				stall_left = calm_phase ? 0 : idle_length();
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
				stall_left = idle_length();
			end
			res_if.ready <= (stall_left == 0);
		end
	end

	// Watchdog on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int roll;
		int base_r;
		int base_c;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		res_if.ready = 1'b0;
		for (int r = 0; r < GRID_H; r++)
			for (int c = 0; c < GRID_W; c++)
				life_grid[r][c] = 1'b0;

		// Directed part: empty grid, unused code, corner and edge patterns.
		push_cmd(CMD_READ, 63, 63, 1'b0);
		push_cmd(CMD_STEP, 0, 0, 1'b0);
		push_cmd(CMD_UNUSED, 63, 63, 1'b1);
		// Corner L that should close into a block.
		push_cmd(CMD_WRITE, 0, 0, 1'b1);
		push_cmd(CMD_WRITE, 0, 1, 1'b1);
		push_cmd(CMD_WRITE, 1, 0, 1'b1);
		// Vertical blinker against the right edge; nothing may appear in column 0.
		push_cmd(CMD_WRITE, 30, 63, 1'b1);
		push_cmd(CMD_WRITE, 31, 63, 1'b1);
		push_cmd(CMD_WRITE, 32, 63, 1'b1);
		push_cmd(CMD_STEP, 63, 63, 1'b1);
		push_cmd(CMD_READ, 1, 1, 1'b0);
		push_cmd(CMD_READ, 31, 62, 1'b0);
		push_cmd(CMD_READ, 31, 0, 1'b0);
		// Clearing a cell, and a lone cell that dies.
		push_cmd(CMD_WRITE, 1, 1, 1'b0);
		push_cmd(CMD_READ, 1, 1, 1'b0);
		push_cmd(CMD_WRITE, 63, 0, 1'b1);
		push_cmd(CMD_READ, 63, 0, 1'b1);
		push_cmd(CMD_STEP, 0, 63, 1'b0);
		push_cmd(CMD_READ, 63, 0, 1'b0);
		push_cmd(CMD_READ, 0, 0, 1'b1);
		push_cmd(CMD_UNUSED, 0, 0, 1'b0, 1'b1);

		// Random part: mostly small patterns written into a window, stepped and
		// probed, with stray accesses, unused codes and bare steps mixed in.
		while (useful_count < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				case ($urandom_range(0, 3))
					0: base_r = 0;
					1: base_r = GRID_H - 4;
					default: base_r = $urandom_range(0, GRID_H - 4);
				endcase
				case ($urandom_range(0, 3))
					0: base_c = 0;
					1: base_c = GRID_W - 4;
					default: base_c = $urandom_range(0, GRID_W - 4);
				endcase
				repeat ($urandom_range(4, 10))
					push_cmd(CMD_WRITE, base_r + $urandom_range(0, 3),
						base_c + $urandom_range(0, 3), $urandom_range(0, 9) != 0);
				repeat ($urandom_range(1, 2))
					push_cmd(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
				repeat ($urandom_range(2, 4))
					push_cmd(CMD_READ, base_r + $urandom_range(0, 3),
						base_c + $urandom_range(0, 3), 1'($urandom_range(0, 1)));
			end else if (roll < 85) begin
				repeat ($urandom_range(1, 3))
					push_cmd($urandom_range(0, 1) ? CMD_READ : CMD_WRITE,
						$urandom_range(0, 63), $urandom_range(0, 63),
						1'($urandom_range(0, 1)));
			end else if (roll < 93) begin
				push_cmd(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
			end else begin
				push_cmd(CMD_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1)));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every command to go in and every response to come back.
		while (command_queue.size() != 0 || cmd_if.valid || items_sent != results_seen)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_responses.size() != 0) begin
			$error("%0d responses never arrived", expected_responses.size());
			failures++;
		end
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: life_generation_engine.f
sv/lge_pkg.sv
sv/lge_chan_if.sv
sv/lge_cell_unit.sv
sv/life_generation_engine.sv
sv/lge_checker.sv
sim/life_generation_engine_tb.sv
